@@ hdl/vjs_pkg.sv @@
// Shared types and constants for the velocity jump sigmoid shaper.
`default_nettype none
package vjs_pkg;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_ROOT    = 8'b0000_0010,
    ST_DECIDE  = 8'b0000_0100,
    ST_FETCH   = 8'b0000_1000,
    ST_CHECK   = 8'b0001_0000,
    ST_MUL_LAT = 8'b0010_0000,
    ST_MUL_FWD = 8'b0100_0000,
    ST_WRITE   = 8'b1000_0000
  } vjs_state_e;

  typedef struct packed {
    logic load;
    logic root_step;
    logic decide;
    logic fetch;
    logic check;
    logic mul_lat;
    logic mul_fwd;
    logic write;
  } vjs_cmd_t;

  typedef struct packed {
    logic out_free;
  } vjs_status_t;

  localparam int unsigned RootSteps = 16;
  localparam logic [15:0] ThresholdReset = 16'd1000;

  localparam logic [1:0] PHASE_NONE  = 2'd0;
  localparam logic [1:0] PHASE_ACCEL = 2'd1;
  localparam logic [1:0] PHASE_DECEL = 2'd2;

endpackage
`default_nettype wire

@@ hdl/vjs_ctrl.sv @@
// Controller state machine sequencing one beat through the shaper datapath.
`default_nettype none
module vjs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire vjs_pkg::vjs_status_t status_i,
  output vjs_pkg::vjs_cmd_t         cmd_o
);
  import vjs_pkg::*;

  vjs_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == 4'(RootSteps - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_MUL_LAT;
      end
      ST_MUL_LAT: begin
        cmd_o.mul_lat = 1'b1;
        state_d       = ST_MUL_FWD;
      end
      ST_MUL_FWD: begin
        cmd_o.mul_fwd = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/vjs_datapath.sv @@
// Datapath of the shaper: square root, ramp state, gain tables and scaling.
`default_nettype none
module vjs_datapath #(
  parameter int unsigned RAMP_STEPS = 2048,
  parameter int unsigned GAIN_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vjs_pkg::vjs_cmd_t cmd_i,
  output vjs_pkg::vjs_status_t   status_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [15:0]       jump_threshold_i,
  input  wire logic signed [15:0] lateral_in_i,
  input  wire logic signed [15:0] forward_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [15:0]     lateral_out_o,
  output logic signed [15:0]     forward_out_o,
  output logic [1:0]             ramp_phase_o
);
  import vjs_pkg::*;

  localparam int unsigned SW = $clog2(RAMP_STEPS);
  localparam int unsigned GF = GAIN_BITS - 1;
  localparam logic [SW-1:0] STEP_MAX = SW'(RAMP_STEPS - 1);
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GF;
  localparam logic [GAIN_BITS+9:0] ACC_LIM = (GAIN_BITS + 10)'(999) << GF;
  localparam logic [GAIN_BITS+6:0] DEC_LIM = (GAIN_BITS + 7)'(1) << GF;

  typedef logic [GAIN_BITS-1:0] gain_rom_t [RAMP_STEPS];

  function automatic longint div_small(input longint t, input int d);
    case (d)
      2:       return t >>> 1;
      3:       return t / 3;
      4:       return t >>> 2;
      5:       return t / 5;
      6:       return t / 6;
      7:       return t / 7;
      8:       return t >>> 3;
      9:       return t / 9;
      10:      return t / 10;
      11:      return t / 11;
      12:      return t / 12;
      13:      return t / 13;
      14:      return t / 14;
      default: return t;
    endcase
  endfunction

  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic gain_rom_t build_rom(input bit decel);
    gain_rom_t        rom;
    longint           num;
    longint unsigned  mag;
    longint unsigned  v;
    longint unsigned  m;
    longint           r;
    longint           term;
    longint           sum;
    longint           s;
    longint           denom;
    longint           top;
    bit               neg;
    for (int n = 0; n < int'(RAMP_STEPS); n++) begin
      num = decel ? (8 * longint'(n) - 300) : (200000 - 672 * longint'(n));
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      v   = decel ? (mag << 30) / 100 : (mag << 30) / 100000;
      s   = 0;
      if (v < (longint'(32) << 30)) begin
        m    = v / 744261118;
        r    = longint'(v - m * 744261118);
        term = longint'(1) << 30;
        sum  = longint'(1) << 30;
        for (int i = 1; i <= 14; i++) begin
          term = div_small((term * r) >>> 30, i);
          sum  = (i % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0) begin
          sum = 0;
        end
        s = sum >> m;
      end
      denom  = (longint'(1) << 30) + s;
      top    = neg ? (longint'(1) << 30) : s;
      rom[n] = GAIN_BITS'(long_div(unsigned'((top << GF) + (denom >>> 1)),
                                   unsigned'(denom)));
    end
    return rom;
  endfunction

  localparam gain_rom_t ACC_ROM = build_rom(1'b0);
  localparam gain_rom_t DEC_ROM = build_rom(1'b1);

  logic [15:0]           thr_q;
  logic signed [15:0]    lat_q, fwd_q;
  logic [31:0]           v_q;
  logic [18:0]           rem_q;
  logic [16:0]           root_q;
  logic [16:0]           prev_q;
  logic                  accel_q, decel_q;
  logic [SW-1:0]         step_q;
  logic [GAIN_BITS-1:0]  gain_q;
  logic signed [15:0]    held_lat_q, held_fwd_q;
  logic signed [15:0]    res_lat_q, res_fwd_q;
  logic                  out_valid_q;
  logic signed [15:0]    out_lat_q, out_fwd_q;
  logic [1:0]            out_phase_q;

  logic signed [31:0]    lat_w, fwd_w;
  logic [18:0]           rem_sh, trial;
  logic signed [17:0]    diff;
  logic                  jump_up, jump_down;
  logic                  acc_n, dec_n;
  logic [SW-1:0]         step_base, step_inc;
  logic                  gain_end;
  logic signed [15:0]    src;
  logic [16:0]           mag;
  logic [GAIN_BITS+16:0] prod;
  logic [16:0]           scaled;
  logic signed [15:0]    scaled_s;

  assign cfg_ready_o = 1'b1;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign lateral_out_o = out_lat_q;
  assign forward_out_o = out_fwd_q;
  assign ramp_phase_o  = out_phase_q;

  always_comb begin
    lat_w = 32'(lateral_in_i);
    fwd_w = 32'(forward_in_i);
  end

  always_comb begin
    rem_sh = {rem_q[16:0], v_q[31:30]};
    trial  = {root_q, 2'b01};
  end

  always_comb begin
    diff      = $signed({1'b0, root_q}) - $signed({1'b0, prev_q});
    jump_up   = diff > $signed({2'b00, thr_q});
    jump_down = diff < -$signed({2'b00, thr_q});
    acc_n     = jump_up ? 1'b1 : (jump_down ? 1'b0 : accel_q);
    dec_n     = jump_up ? 1'b0 : (jump_down ? 1'b1 : decel_q);
    step_base = (jump_up || jump_down) ? '0 : step_q;
    step_inc  = (step_base >= STEP_MAX) ? STEP_MAX : step_base + SW'(1);
  end

  always_comb begin
    if (accel_q) begin
      gain_end = ((GAIN_BITS + 10)'(gain_q) * (GAIN_BITS + 10)'(1000)) > ACC_LIM;
    end else begin
      gain_end = ((GAIN_BITS + 7)'(gain_q) * (GAIN_BITS + 7)'(100)) < DEC_LIM;
    end
  end

  always_comb begin
    if (cmd_i.mul_lat) begin
      src = decel_q ? held_lat_q : lat_q;
    end else begin
      src = decel_q ? held_fwd_q : fwd_q;
    end
    mag      = src[15] ? 17'(-{src[15], src}) : 17'({1'b0, src});
    prod     = (GAIN_BITS + 17)'(mag) * (GAIN_BITS + 17)'(gain_q)
               + (GAIN_BITS + 17)'(GAIN_ONE >> 1);
    scaled   = 17'(prod >> GF);
    scaled_s = src[15] ? 16'(-scaled) : scaled[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThresholdReset;
      prev_q      <= '0;
      accel_q     <= 1'b0;
      decel_q     <= 1'b0;
      step_q      <= '0;
      held_lat_q  <= '0;
      held_fwd_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= jump_threshold_i;
      end
      if (cmd_i.decide) begin
        prev_q  <= root_q;
        accel_q <= acc_n;
        decel_q <= dec_n;
        step_q  <= (acc_n || dec_n) ? step_inc : '0;
      end
      if (cmd_i.check && (accel_q || decel_q) && gain_end) begin
        accel_q <= 1'b0;
        decel_q <= 1'b0;
        step_q  <= '0;
      end
      if (cmd_i.write && !decel_q) begin
        held_lat_q <= res_lat_q;
        held_fwd_q <= res_fwd_q;
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lat_q  <= lateral_in_i;
      fwd_q  <= forward_in_i;
      v_q    <= lat_w * lat_w + fwd_w * fwd_w;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      v_q <= {v_q[29:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[15:0], 1'b0};
      end
    end
    if (cmd_i.fetch) begin
      gain_q <= accel_q ? ACC_ROM[step_q] : DEC_ROM[step_q];
    end
    if (cmd_i.check) begin
      if (!(accel_q || decel_q) || gain_end) begin
        gain_q <= GAIN_ONE;
      end
    end
    if (cmd_i.mul_lat) begin
      res_lat_q <= scaled_s;
    end
    if (cmd_i.mul_fwd) begin
      res_fwd_q <= scaled_s;
    end
    if (cmd_i.write) begin
      out_lat_q   <= res_lat_q;
      out_fwd_q   <= res_fwd_q;
      out_phase_q <= accel_q ? PHASE_ACCEL : (decel_q ? PHASE_DECEL : PHASE_NONE);
    end
  end

endmodule
`default_nettype wire

@@ hdl/velocity_jump_sigmoid_shaper_unit.sv @@
// Top level of the velocity jump sigmoid shaper.
// The input channel (in_valid_i/in_ready_o) carries one beat per control tick:
// a signed lateral and forward velocity target. The output channel
// (out_valid_o/out_ready_i) returns one beat per input beat: the shaped
// targets and the ramp phase (none, accelerating, decelerating).
// The configuration channel (cfg_valid_i/cfg_ready_o) writes the jump
// threshold; it is always ready and should be used only while the block idles.
// Each beat passes from acceptance to a valid result through the bit-serial
// square root, the ramp decision, the gain table read and the end-of-ramp
// check, one shared multiplier used for the lateral and then the forward
// target, and the load of the output register. A new input beat is accepted
// once the previous result has moved into the output register, so the block
// does not take a new beat while the previous one is still being processed.
// If the receiver stalls, the finished result waits in the output register;
// the next beat is still processed and waits at its final step.
// Reset clears the ramp state, held outputs and previous speed, and sets the
// threshold to 1000.
`default_nettype none
module velocity_jump_sigmoid_shaper_unit #(
  parameter int unsigned RAMP_STEPS = 2048,
  parameter int unsigned GAIN_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        jump_threshold_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] lateral_in_i,
  input  wire logic signed [15:0] forward_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      lateral_out_o,
  output logic signed [15:0]      forward_out_o,
  output logic [1:0]              ramp_phase_o
);
  import vjs_pkg::*;

  vjs_cmd_t    cmd;
  vjs_status_t status;

  vjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vjs_datapath #(
    .RAMP_STEPS (RAMP_STEPS),
    .GAIN_BITS  (GAIN_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .jump_threshold_i (jump_threshold_i),
    .lateral_in_i     (lateral_in_i),
    .forward_in_i     (forward_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .lateral_out_o    (lateral_out_o),
    .forward_out_o    (forward_out_o),
    .ramp_phase_o     (ramp_phase_o)
  );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the velocity jump sigmoid shaper unit.
`default_nettype none
module testbench;
  import vjs_pkg::*;

  localparam int unsigned RampSteps = 2048;
  localparam int unsigned GainFrac = 15;
  localparam longint GainOne = 64'sd1 << GainFrac;
  localparam longint Q30One = 64'sd1 << 30;
  localparam longint Ln2Q30 = 64'sd744261118;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 40;

  typedef struct {
    logic signed [15:0] lat;
    logic signed [15:0] fwd;
  } velocity_t;

  typedef struct {
    logic signed [15:0] lat;
    logic signed [15:0] fwd;
    logic [1:0]         phase;
  } shaped_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] jump_threshold_i = 16'd0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] lateral_in_i = 16'sd0;
  logic signed [15:0] forward_in_i = 16'sd0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] lateral_out_o;
  logic signed [15:0] forward_out_o;
  logic [1:0] ramp_phase_o;

  velocity_t pending_q[$];
  shaped_t shaped_q[$];
  int unsigned issued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;

  logic [15:0] threshold = ThresholdReset;
  int unsigned prev_speed = 0;
  bit accel_on = 1'b0;
  bit decel_on = 1'b0;
  int unsigned ramp_n = 0;
  int held_lat = 0;
  int held_fwd = 0;
  longint accel_gain[RampSteps];
  longint decel_gain[RampSteps];

  velocity_jump_sigmoid_shaper_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .jump_threshold_i(jump_threshold_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .lateral_in_i    (lateral_in_i),
    .forward_in_i    (forward_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lateral_out_o   (lateral_out_o),
    .forward_out_o   (forward_out_o),
    .ramp_phase_o    (ramp_phase_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Logistic 1/(1+e^(num/den)) in Q1.15, with e^-|u| from a floored Taylor series.
  function automatic longint logistic(longint num, longint den);
    bit neg;
    longint unsigned mag;
    longint unsigned v;
    longint unsigned m;
    longint r;
    longint term;
    longint sum;
    longint s;
    longint denom;
    longint top;
    neg = num < 0;
    mag = neg ? -num : num;
    v = (mag << 30) / den;
    s = 0;
    if (v < (64'd32 << 30)) begin
      m = v / Ln2Q30;
      r = v - m * Ln2Q30;
      term = Q30One;
      sum = Q30One;
      for (int i = 1; i <= 14; i++) begin
        term = longint'((longint'(term) * r) >>> 30) / i;
        sum = (i % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      s = sum >>> m;
    end
    denom = Q30One + s;
    top = neg ? Q30One : s;
    return ((top << GainFrac) + denom / 2) / denom;
  endfunction

  function automatic int apply_gain(int v, longint g);
    longint unsigned mag;
    longint unsigned p;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    p = (mag * g + GainOne / 2) >> GainFrac;
    return (v < 0) ? -int'(p) : int'(p);
  endfunction

  function automatic shaped_t shape_tick(velocity_t x);
    shaped_t o;
    int lat;
    int fwd;
    int unsigned speed;
    longint diff;
    longint g;
    lat = x.lat;
    fwd = x.fwd;
    speed = int_sqrt(longint'(lat) * lat + longint'(fwd) * fwd);
    diff = longint'(speed) - longint'(prev_speed);
    g = GainOne;
    if (diff > longint'(threshold)) begin
      accel_on = 1'b1;
      decel_on = 1'b0;
      ramp_n = 0;
    end else if (diff < -longint'(threshold)) begin
      accel_on = 1'b0;
      decel_on = 1'b1;
      ramp_n = 0;
    end
    if (accel_on || decel_on) begin
      ramp_n = (ramp_n + 1 > RampSteps - 1) ? RampSteps - 1 : ramp_n + 1;
      if (accel_on) begin
        g = accel_gain[ramp_n];
        if (g * 1000 > 999 * GainOne) accel_on = 1'b0;
      end else begin
        g = decel_gain[ramp_n];
        if (g * 100 < GainOne) decel_on = 1'b0;
      end
      if (!accel_on && !decel_on) begin
        g = GainOne;
        ramp_n = 0;
      end
    end else begin
      ramp_n = 0;
    end
    if (accel_on) begin
      o.lat = apply_gain(lat, g);
      o.fwd = apply_gain(fwd, g);
      o.phase = PHASE_ACCEL;
    end else if (decel_on) begin
      o.lat = apply_gain(held_lat, g);
      o.fwd = apply_gain(held_fwd, g);
      o.phase = PHASE_DECEL;
    end else begin
      o.lat = x.lat;
      o.fwd = x.fwd;
      o.phase = PHASE_NONE;
    end
    if (!decel_on) begin
      held_lat = o.lat;
      held_fwd = o.fwd;
    end
    prev_speed = speed;
    return o;
  endfunction

  function automatic logic signed [15:0] near(int base, int spread);
    int v;
    v = base + $urandom_range(2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic push(int lat, int fwd);
    velocity_t x;
    x.lat = lat;
    x.fwd = fwd;
    pending_q.push_back(x);
  endtask

  task automatic hold_near(int lat, int fwd, int len, int spread);
    for (int i = 0; i < len; i++) push(near(lat, spread), near(fwd, spread));
  endtask

  task automatic mixed_traffic(int len);
    int lat;
    int fwd;
    int seg;
    while (len > 0) begin
      lat = $signed(16'($urandom));
      fwd = $signed(16'($urandom));
      if ($urandom_range(9) < 2) begin
        push(lat, fwd);
        len--;
      end else begin
        seg = $urandom_range(1, 60);
        hold_near(lat, fwd, seg, $urandom_range(0, 300));
        len -= seg;
      end
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && shaped_q.size() == 0 && !in_valid_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    jump_threshold_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic bit busy_now();
    if (cycle_cnt > 30000 && cycle_cnt < 45000) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !busy_now();
      if (!in_valid_i || accepted_cnt == issued_cnt) begin
        if (pending_q.size() != 0 && !busy_now()) begin
          lateral_in_i <= pending_q[0].lat;
          forward_in_i <= pending_q[0].fwd;
          void'(pending_q.pop_front());
          in_valid_i <= 1'b1;
          issued_cnt <= issued_cnt + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    shaped_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      if (rst_ni && in_valid_i && in_ready_o) begin
        velocity_t x;
        x.lat = lateral_in_i;
        x.fwd = forward_in_i;
        shaped_q.push_back(shape_tick(x));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("Unexpected output beat at cycle %0d", cycle_cnt);
        end else begin
          want = shaped_q.pop_front();
          if (lateral_out_o !== want.lat || forward_out_o !== want.fwd ||
              ramp_phase_o !== want.phase) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("Mismatch: expected lat %0d fwd %0d phase %0d, got %0d %0d %0d",
                       want.lat, want.fwd, want.phase,
                       lateral_out_o, forward_out_o, ramp_phase_o);
          end
        end
      end
    end
  end

  initial begin
    for (int n = 1; n < RampSteps; n++) begin
      accel_gain[n] = logistic(200000 - 672 * longint'(n), 100000);
      decel_gain[n] = logistic(8 * longint'(n) - 300, 100);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push(0, 0);
    push(32767, 32767);
    push(32767, 32767);
    push(-32768, -32768);
    push(0, 0);
    push(0, 0);
    push(0, 0);
    push(-32768, 0);
    push(0, 32767);
    push(1, -1);
    push(-1, 1);
    push(0, -32768);
    push(-32768, 32767);
    push(0, 0);
    push(1000, 0);
    push(2001, 0);
    push(1001, 0);
    push(-21845, 10922);
    push(0, 0);
    drain();

    // A long acceleration ramp that runs until the gain settles, then a deceleration.
    write_threshold(16'd1000);
    push(0, 0);
    hold_near(20000, -15000, 1400, 100);
    hold_near(100, 100, 120, 40);
    drain();

    write_threshold(16'd0);
    mixed_traffic(60);
    drain();

    write_threshold(16'hFFFF);
    mixed_traffic(40);
    drain();

    write_threshold(16'($urandom_range(1, 4000)));
    mixed_traffic(100);
    drain();

    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
